### hw/rtl/wdb_pkg.sv
// ----------------------------------------------------------------------------
// wdb_pkg
// Shared types, constants and tables of the waypoint distance/bearing core.
// ----------------------------------------------------------------------------
package wdb_pkg;

  // CORDIC rotation count (12 .. 32)
  localparam int unsigned CordicIters = 24;
  localparam int unsigned IterW       = (CordicIters > 1) ? $clog2(CordicIters) : 1;

  // datapath widths
  localparam int unsigned LatW   = 31;
  localparam int unsigned LonW   = 32;
  localparam int unsigned CosW   = 17;
  localparam int unsigned RadW   = 17;
  localparam int unsigned NorthW = 32;
  localparam int unsigned EastW  = 33;
  localparam int unsigned QW     = 45;
  localparam int unsigned XyW    = 44;
  localparam int unsigned ZW     = 33;
  localparam int unsigned DistW  = 32;
  localparam int unsigned BrgW   = 16;
  localparam int unsigned FracBits = 8;

  // fixed-point constants
  localparam logic [28:0]     CmPerUnitQ28 = 29'd298486608;
  localparam logic [31:0]     InvGainQ32   = 32'd2608131496;
  localparam logic [CosW-1:0] CosOne       = 17'd65536;
  localparam logic [15:0]     CentiDegTurn = 16'd36000;

  // short queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  typedef enum logic [1:0] {
    CFG_TARGET_LAT = 2'd0,
    CFG_TARGET_LON = 2'd1,
    CFG_COS_REF    = 2'd2,
    CFG_ACC_RADIUS = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROTATE,
    BK_SCALE,
    BK_ROUND,
    BK_EMIT
  } bk_state_e;

  typedef struct packed {
    logic [LatW-1:0] target_lat;
    logic [LonW-1:0] target_lon;
    logic [CosW-1:0] cos_ref;
    logic [RadW-1:0] acc_radius;
  } wdb_cfg_t;

  // one classified fix, ready for the vectoring unit
  typedef struct packed {
    logic [NorthW-1:0] north;
    logic [EastW-1:0]  east;
    logic              lat_neg;
    logic              lon_neg;
  } wdb_job_t;

  // arctangent of 2^-i in binary angle units (2^32 per turn)
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/waypoint_distance_bearing_core.sv
// ----------------------------------------------------------------------------
// waypoint_distance_bearing_core
// Ground distance and bearing from a position fix to a configured waypoint.
// ----------------------------------------------------------------------------
//
//  channel   | handshake             | payload
//  ----------+-----------------------+----------------------------------------
//  in        | in_valid_i/in_ready_o | current_latitude_i, current_longitude_i
//  out       | out_valid_o/out_ready_i | distance_cm_o, bearing_centidegrees_o,
//            |                       | reached_o
//  cfg       | cfg_we_i (no wait)    | cfg_idx_i, cfg_wdata_i
//
//  An accepted fix passes the front stages, a queue write, then the back states
//  accept, CordicIters rotations, scale, round and emit; the back part takes
//  no new fix before it emits the last: there is a single CORDIC rotation stage.
//  Reset clears all handshake state and loads the register reset values.
//  A stalled output holds its beat; the back part then parks at its last step
//  while the front keeps filling the two-entry queue before it stalls input.
// ----------------------------------------------------------------------------
module waypoint_distance_bearing_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [31:0]                cfg_wdata_i,
  // position fix in
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [wdb_pkg::LatW-1:0]   current_latitude_i,
  input  logic [wdb_pkg::LonW-1:0]   current_longitude_i,
  // result out
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [wdb_pkg::DistW-1:0]  distance_cm_o,
  output logic [wdb_pkg::BrgW-1:0]   bearing_centidegrees_o,
  output logic                       reached_o
);
  import wdb_pkg::*;

  wdb_cfg_t cfg_q, cfg_d;
  wdb_job_t front_job, back_job;
  logic     front_vld, front_rdy, back_vld, back_rdy;

  // register file: write takes effect on the enable edge, unused bits drop
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TARGET_LAT: cfg_d.target_lat = cfg_wdata_i[LatW-1:0];
        CFG_TARGET_LON: cfg_d.target_lon = cfg_wdata_i[LonW-1:0];
        CFG_COS_REF:    cfg_d.cos_ref    = cfg_wdata_i[CosW-1:0];
        CFG_ACC_RADIUS: cfg_d.acc_radius = cfg_wdata_i[RadW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_lat <= '0;
      cfg_q.target_lon <= '0;
      cfg_q.cos_ref    <= CosOne;
      cfg_q.acc_radius <= RadW'(1000);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: offsets and scaling to centimetres
  wdb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .lat_i       (current_latitude_i),
    .lon_i       (current_longitude_i),
    .job_valid_o (front_vld),
    .job_ready_i (front_rdy),
    .job_o       (front_job)
  );

  // decouple: let either side stall on its own
  wdb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_vld),
    .push_ready_o (front_rdy),
    .push_data_i  (front_job),
    .pop_valid_o  (back_vld),
    .pop_ready_i  (back_rdy),
    .pop_data_o   (back_job)
  );

  // back: vectoring, gain correction, bearing, result register
  wdb_back u_back (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .acc_radius_i           (cfg_q.acc_radius),
    .job_valid_i            (back_vld),
    .job_ready_o            (back_rdy),
    .job_i                  (back_job),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .distance_cm_o          (distance_cm_o),
    .bearing_centidegrees_o (bearing_centidegrees_o),
    .reached_o              (reached_o)
  );

endmodule

### hw/rtl/wdb_front.sv
// ----------------------------------------------------------------------------
// wdb_front
// Four-stage front: offsets, magnitudes and equirectangular scaling to cm.
// ----------------------------------------------------------------------------
module wdb_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  wdb_pkg::wdb_cfg_t         cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [wdb_pkg::LatW-1:0]  lat_i,
  input  logic [wdb_pkg::LonW-1:0]  lon_i,
  output logic                      job_valid_o,
  input  logic                      job_ready_i,
  output wdb_pkg::wdb_job_t         job_o
);
  import wdb_pkg::*;

  localparam logic [61:0] RndN = 62'd1 << 27;
  localparam logic [61:0] RndQ = 62'd1 << 15;
  localparam logic [61:0] RndE = 62'd1 << 27;

  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic adv;

  logic signed [LatW:0] dlat_d, dlat_q;
  logic signed [LonW:0] dlon_d, dlon_q;
  logic [LatW:0]        mlat_d, mlat_q;
  logic [LonW:0]        mlon_d, mlon_q;
  logic                 s2_lat_neg_q, s2_lon_neg_q;
  logic                 s3_lat_neg_q, s3_lon_neg_q;
  logic [61:0]          nsum, qsum, esum;
  logic [NorthW-1:0]    s3_north_q;
  logic [QW-1:0]        s3_q_q;
  logic [CosW-1:0]      cos_sat_d, s3_cos_q;
  wdb_job_t             s4_job_d, s4_job_q;

  // one enable for the whole pipe: hold everything while the last beat waits
  assign adv        = !s4_vld_q || job_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    dlat_d = $signed({cfg_i.target_lat[LatW-1], cfg_i.target_lat})
           - $signed({lat_i[LatW-1], lat_i});
    dlon_d = $signed({cfg_i.target_lon[LonW-1], cfg_i.target_lon})
           - $signed({lon_i[LonW-1], lon_i});
    mlat_d = dlat_q[LatW] ? (LatW + 1)'(-dlat_q) : (LatW + 1)'(dlat_q);
    mlon_d = dlon_q[LonW] ? (LonW + 1)'(-dlon_q) : (LonW + 1)'(dlon_q);
    cos_sat_d = (cfg_i.cos_ref > CosOne) ? CosOne : cfg_i.cos_ref;
    nsum = 62'(mlat_q) * 62'(CmPerUnitQ28) + RndN;
    qsum = 62'(mlon_q) * 62'(CmPerUnitQ28) + RndQ;
    esum = 62'(s3_q_q) * 62'(s3_cos_q) + RndE;
    s4_job_d.north   = s3_north_q;
    s4_job_d.east    = esum[60:28];
    s4_job_d.lat_neg = s3_lat_neg_q;
    s4_job_d.lon_neg = s3_lon_neg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dlat_q       <= dlat_d;
      dlon_q       <= dlon_d;
      mlat_q       <= mlat_d;
      mlon_q       <= mlon_d;
      s2_lat_neg_q <= dlat_q[LatW];
      s2_lon_neg_q <= dlon_q[LonW];
      s3_north_q   <= nsum[59:28];
      s3_q_q       <= qsum[60:16];
      s3_cos_q     <= cos_sat_d;
      s3_lat_neg_q <= s2_lat_neg_q;
      s3_lon_neg_q <= s2_lon_neg_q;
      s4_job_q     <= s4_job_d;
    end
  end

  assign job_valid_o = s4_vld_q;
  assign job_o       = s4_job_q;

endmodule

### hw/rtl/wdb_queue.sv
// ----------------------------------------------------------------------------
// wdb_queue
// Short FIFO of classified fixes between front and back.
// ----------------------------------------------------------------------------
module wdb_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  wdb_pkg::wdb_job_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output wdb_pkg::wdb_job_t pop_data_o
);
  import wdb_pkg::*;

  localparam logic [QPtrW-1:0] LastPtr = QPtrW'(QueueDepth - 1);

  wdb_job_t         mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != (QPtrW + 1)'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hw/rtl/wdb_back.sv
// ----------------------------------------------------------------------------
// wdb_back
// CORDIC vectoring sequencer, gain correction, bearing scaling, result register.
// ----------------------------------------------------------------------------
module wdb_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [wdb_pkg::RadW-1:0]   acc_radius_i,
  input  logic                       job_valid_i,
  output logic                       job_ready_o,
  input  wdb_pkg::wdb_job_t          job_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [wdb_pkg::DistW-1:0]  distance_cm_o,
  output logic [wdb_pkg::BrgW-1:0]   bearing_centidegrees_o,
  output logic                       reached_o
);
  import wdb_pkg::*;

  localparam logic [IterW-1:0] LastIter = IterW'(CordicIters - 1);
  localparam logic [ZW-1:0]    QuarterTurn = ZW'(33'd1 << 30);
  localparam logic [59:0]      RndDist = 60'd1 << 23;
  localparam logic [47:0]      RndBrg  = 48'd1 << 31;

  bk_state_e state_q, state_d;

  logic signed [XyW-1:0] x_q, y_q, xs, ys;
  logic signed [ZW-1:0]  z_q;
  logic [IterW-1:0]      iter_q;
  logic                  lat_neg_q, lon_neg_q, zero_q;
  logic [ZW-1:0]         step_ang;

  logic [30:0]           a_clamp;
  logic [31:0]           ang_d, ang_q;
  logic [XyW-2:0]        ux;
  logic [58:0]           phi_q;
  logic [31:0]           plo_q;
  logic [47:0]           plo_full, brg_full;
  logic [59:0]           psum;
  logic [35:0]           dist_raw_q;
  logic [BrgW-1:0]       cd_q;
  logic [DistW-1:0]      dist_sat;

  logic                  out_vld_q;
  logic                  emit;

  // next state and handshake
  always_comb begin
    state_d     = state_q;
    job_ready_o = 1'b0;
    emit        = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          state_d = BK_ROTATE;
        end
      end
      BK_ROTATE: begin
        if (iter_q == LastIter) begin
          state_d = BK_SCALE;
        end
      end
      BK_SCALE: state_d = BK_ROUND;
      BK_ROUND: state_d = BK_EMIT;
      BK_EMIT: begin
        if (!out_vld_q || out_ready_i) begin
          emit    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath terms
  always_comb begin
    xs       = x_q >>> iter_q;
    ys       = y_q >>> iter_q;
    step_ang = {1'b0, atan_lut(5'(iter_q))};

    if (z_q[ZW-1]) begin
      a_clamp = '0;
    end else if (z_q > $signed(QuarterTurn)) begin
      a_clamp = 31'(QuarterTurn);
    end else begin
      a_clamp = z_q[30:0];
    end

    priority if (zero_q) begin
      ang_d = '0;
    end else if (!lat_neg_q && !lon_neg_q) begin
      ang_d = {1'b0, a_clamp};
    end else if (lat_neg_q && !lon_neg_q) begin
      ang_d = 32'h8000_0000 - {1'b0, a_clamp};
    end else if (lat_neg_q) begin
      ang_d = 32'h8000_0000 + {1'b0, a_clamp};
    end else begin
      ang_d = 32'd0 - {1'b0, a_clamp};
    end

    ux       = x_q[XyW-1] ? '0 : x_q[XyW-2:0];
    plo_full = 48'(ux[15:0]) * 48'(InvGainQ32);
    psum     = 60'(phi_q) + 60'(plo_q) + RndDist;
    brg_full = 48'(ang_q) * 48'(CentiDegTurn) + RndBrg;
    dist_sat = (dist_raw_q[35:32] != '0) ? '1 : dist_raw_q[31:0];
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BK_IDLE: begin
        x_q       <= $signed(XyW'({job_i.north, {FracBits{1'b0}}}));
        y_q       <= $signed(XyW'({job_i.east, {FracBits{1'b0}}}));
        z_q       <= '0;
        iter_q    <= '0;
        lat_neg_q <= job_i.lat_neg;
        lon_neg_q <= job_i.lon_neg;
        zero_q    <= (job_i.north == '0) && (job_i.east == '0);
      end
      BK_ROTATE: begin
        // rotate toward y = 0
        if (!y_q[XyW-1]) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + $signed(step_ang);
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - $signed(step_ang);
        end
        iter_q <= iter_q + 1'b1;
      end
      BK_SCALE: begin
        ang_q <= ang_d;
        phi_q <= 59'(ux[XyW-2:16]) * 59'(InvGainQ32);
        plo_q <= plo_full[47:16];
      end
      BK_ROUND: begin
        dist_raw_q <= psum[59:24];
        cd_q       <= brg_full[47:32];
      end
      BK_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // result register: holds a beat while the next fix is being worked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      distance_cm_o          <= dist_sat;
      bearing_centidegrees_o <= (cd_q >= CentiDegTurn) ? '0 : cd_q;
      reached_o              <= (dist_sat <= DistW'(acc_radius_i));
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

### dv/wdb_fix_checker.sv
// ----------------------------------------------------------------------------
// wdb_fix_checker
// Watches the config port and both channels of the waypoint distance/bearing
// core, predicts one result per accepted fix and compares each result beat
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module wdb_fix_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [31:0]                 cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [wdb_pkg::LatW-1:0]    current_latitude_i,
  input  logic [wdb_pkg::LonW-1:0]    current_longitude_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [wdb_pkg::DistW-1:0]   distance_cm_i,
  input  logic [wdb_pkg::BrgW-1:0]    bearing_centidegrees_i,
  input  logic                        reached_i,
  output int unsigned                 mismatches_o,
  output int unsigned                 backlog_o
);
  import wdb_pkg::*;

  typedef struct packed {
    logic [DistW-1:0] distance_cm;
    logic [BrgW-1:0]  bearing_cdeg;
    logic             reached;
  } nav_fix_t;

  // centimetres per 1e-7 degree (Q28) and inverse CORDIC gain (Q32)
  localparam longint unsigned CmPerUnitQ28 = 64'd298486608;
  localparam longint unsigned InvGainQ32   = 64'd2608131496;
  localparam longint unsigned UnitCos      = 64'd65536;

  // arctan(2^-i) in binary angle units, 2^32 per turn
  longint arctan_bam [0:31] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  // shadow of the waypoint registers
  longint          wp_lat;
  longint          wp_lon;
  longint unsigned cos_q16;
  longint unsigned radius_cm;

  nav_fix_t    fixes_due [$];
  int unsigned bad_beats;

  function automatic nav_fix_t range_bearing_of(input logic [LatW-1:0] lat_bits,
                                                input logic [LonW-1:0] lon_bits);
    nav_fix_t        res;
    longint          dlat, dlon, x, y, z, xs, ys;
    longint unsigned lat_mag, lon_mag, cosv, north, q, east, ux, p, dist_cm, cd;
    logic [31:0]     a, ang;
    dlat    = wp_lat - longint'($signed(lat_bits));
    dlon    = wp_lon - longint'($signed(lon_bits));
    lat_mag = (dlat < 0) ? -dlat : dlat;
    lon_mag = (dlon < 0) ? -dlon : dlon;
    cosv    = (cos_q16 > UnitCos) ? UnitCos : cos_q16;
    north   = (lat_mag * CmPerUnitQ28 + (64'd1 << 27)) >> 28;
    q       = (lon_mag * CmPerUnitQ28 + (64'd1 << 15)) >> 16;
    east    = (q * cosv + (64'd1 << 27)) >> 28;
    dist_cm = 0;
    ang     = '0;
    if (north != 0 || east != 0) begin
      x = longint'(north << FracBits);
      y = longint'(east << FracBits);
      z = 0;
      // vector toward y = 0, floor shifts
      for (int i = 0; i < CordicIters && i < 32; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + arctan_bam[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - arctan_bam[i];
        end
      end
      if (z < 0) z = 0;
      if (z > (longint'(1) << 30)) z = longint'(1) << 30;
      a       = z[31:0];
      ux      = (x < 0) ? 64'd0 : 64'(x);
      p       = (ux >> 16) * InvGainQ32 + (((ux & 64'hFFFF) * InvGainQ32) >> 16);
      dist_cm = (p + (64'd1 << 23)) >> 24;
      if (dist_cm > 64'hFFFF_FFFF) dist_cm = 64'hFFFF_FFFF;
      // fold the first-quadrant angle out by the offset signs
      if (dlat >= 0 && dlon >= 0) ang = a;
      else if (dlat < 0 && dlon >= 0) ang = 32'h8000_0000 - a;
      else if (dlat < 0) ang = 32'h8000_0000 + a;
      else ang = 32'd0 - a;
    end
    cd = (64'(ang) * 64'd36000 + (64'd1 << 31)) >> 32;
    if (cd >= 64'd36000) cd = 0;
    res.distance_cm  = dist_cm[DistW-1:0];
    res.bearing_cdeg = cd[BrgW-1:0];
    res.reached      = (dist_cm <= radius_cm);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    nav_fix_t want;
    if (!rst_ni) begin
      wp_lat    = 0;
      wp_lon    = 0;
      cos_q16   = UnitCos;
      radius_cm = 1000;
      fixes_due.delete();
      bad_beats = 0;
      mismatches_o <= 0;
      backlog_o    <= 0;
    end else begin
      // check the result beat before queuing a new fix
      if (out_valid_i && out_ready_i) begin
        if (fixes_due.size() == 0) begin
          if (bad_beats < 10)
            $display("result beat with no fix outstanding: dist %0d brg %0d reached %0b",
                     distance_cm_i, bearing_centidegrees_i, reached_i);
          bad_beats++;
        end else begin
          want = fixes_due.pop_front();
          if (want.distance_cm !== distance_cm_i || want.bearing_cdeg !== bearing_centidegrees_i
              || want.reached !== reached_i) begin
            if (bad_beats < 10)
              $display("mismatch: dist exp %0d got %0d, brg exp %0d got %0d, reached exp %0b got %0b",
                       want.distance_cm, distance_cm_i, want.bearing_cdeg,
                       bearing_centidegrees_i, want.reached, reached_i);
            bad_beats++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        fixes_due.push_back(range_bearing_of(current_latitude_i, current_longitude_i));
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TARGET_LAT: wp_lat    = longint'($signed(cfg_wdata_i[LatW-1:0]));
          CFG_TARGET_LON: wp_lon    = longint'($signed(cfg_wdata_i));
          CFG_COS_REF:    cos_q16   = cfg_wdata_i[CosW-1:0];
          CFG_ACC_RADIUS: radius_cm = cfg_wdata_i[RadW-1:0];
          default: ;
        endcase
      end
      mismatches_o <= bad_beats;
      backlog_o    <= fixes_due.size();
    end
  end

endmodule

### dv/tb_waypoint_distance_bearing_core.sv
// ----------------------------------------------------------------------------
// tb_waypoint_distance_bearing_core
// Drives position fixes into the waypoint distance/bearing core under several
// waypoint settings, with random gaps and stalls on both channels, and lets
// wdb_fix_checker predict and compare every result beat.
// ----------------------------------------------------------------------------
module tb_waypoint_distance_bearing_core;
  import wdb_pkg::*;

  localparam int unsigned StallLimit   = 4000;  // cycles with no beat on either side
  localparam int unsigned HoldCycles   = 400;   // long receiver hold-off
  localparam int unsigned RandPhases   = 8;
  localparam int unsigned FixesPerPhase = 235;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [1:0]        cfg_idx_i;
  logic [31:0]       cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [LatW-1:0]   current_latitude_i;
  logic [LonW-1:0]   current_longitude_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [DistW-1:0]  distance_cm_o;
  logic [BrgW-1:0]   bearing_centidegrees_o;
  logic              reached_o;

  int unsigned mismatches;
  int unsigned backlog;

  // idle odds in percent, and hold-off requests handed to the receiver
  int unsigned send_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned hold_requests;

  // waypoint as last written, used to aim fixes near it
  longint wp_lat;
  longint wp_lon;

  always #4 clk_i = ~clk_i;

  waypoint_distance_bearing_core dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .current_latitude_i     (current_latitude_i),
    .current_longitude_i    (current_longitude_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .distance_cm_o          (distance_cm_o),
    .bearing_centidegrees_o (bearing_centidegrees_o),
    .reached_o              (reached_o)
  );

  wdb_fix_checker u_checker (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .in_valid_i             (in_valid_i),
    .in_ready_i             (in_ready_o),
    .current_latitude_i     (current_latitude_i),
    .current_longitude_i    (current_longitude_i),
    .out_valid_i            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .distance_cm_i          (distance_cm_o),
    .bearing_centidegrees_i (bearing_centidegrees_o),
    .reached_i              (reached_o),
    .mismatches_o           (mismatches),
    .backlog_o              (backlog)
  );

  // Offer one fix. Enter and leave at a falling edge; valid stays up across
  // back-to-back beats and only drops when an idle cycle is drawn.
  task automatic send_fix(input logic [LatW-1:0] lat, input logic [LonW-1:0] lon);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i          <= 1'b1;
    current_latitude_i  <= lat;
    current_longitude_i <= lon;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every fix has come back out.
  task automatic drain();
    in_valid_i <= 1'b0;
    wait (backlog == 0);
    @(negedge clk_i);
  endtask

  // One register write, pulse held for a single cycle; keep our own copy of
  // the waypoint so that random fixes can be aimed near it.
  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] value);
    if (idx == CFG_TARGET_LAT) wp_lat = longint'($signed(value[LatW-1:0]));
    if (idx == CFG_TARGET_LON) wp_lon = longint'($signed(value));
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // Receiver: random ready, plus a long hold-off counted here whenever the
  // stimulus asks for one.
  initial begin : sink
    int unsigned served;
    int unsigned hold_left;
    served      = 0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (served != hold_requests) begin
        served    = hold_requests;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Watchdog: give up when neither channel moves a beat for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    longint      lat_v;
    longint      lon_v;
    int unsigned pick;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_TARGET_LAT;
    cfg_wdata_i         = '0;
    in_valid_i          = 1'b0;
    current_latitude_i  = '0;
    current_longitude_i = '0;
    send_idle_pct       = 16;
    sink_idle_pct       = 16;
    hold_requests       = 0;
    wp_lat              = 0;
    wp_lon              = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // --- directed, reset waypoint (0,0), unit cosine, 1000 cm radius ---
    send_fix('0, '0);                                // same spot: zero, bearing 0, reached
    send_fix(31'(-1), '0);                           // due north
    send_fix(31'(1), '0);                            // due south
    send_fix('0, 32'(-1));                           // due east
    send_fix('0, 32'(1));                            // due west
    send_fix(31'(-899), '0);                         // just inside the radius
    send_fix(31'(-900), '0);                         // just outside
    send_fix(31'(-300), 32'(-400));                  // one fix per quadrant
    send_fix(31'(300), 32'(-400));
    send_fix(31'(300), 32'(400));
    send_fix(31'(-300), 32'(400));
    send_fix(31'(900000000), 32'(1800000000));       // range corners
    send_fix(31'(-900000000), 32'(-1800000000));
    send_fix(31'h3FFF_FFFF, 32'h7FFF_FFFF);          // bit-pattern extremes
    send_fix(31'h4000_0000, 32'h8000_0000);
    drain();

    // waypoint at the field extremes, cosine above one, widest radius
    write_reg(CFG_TARGET_LAT, 32'h4000_0000);
    write_reg(CFG_TARGET_LON, 32'h7FFF_FFFF);
    write_reg(CFG_COS_REF, 32'h1_FFFF);
    write_reg(CFG_ACC_RADIUS, 32'h1_FFFF);
    send_fix(31'h4000_0000, 32'h7FFF_FFFF);          // on the waypoint
    send_fix(31'h3FFF_FFFF, 32'h8000_0000);          // farthest: distance saturates
    send_fix(31'(-1073741824 + 50000), 32'(2147483647 - 80000));
    drain();

    // zero cosine kills the east offset; zero radius needs an exact hit
    write_reg(CFG_TARGET_LAT, 32'(123456789));
    write_reg(CFG_TARGET_LON, 32'(-98765432));
    write_reg(CFG_COS_REF, 32'd0);
    write_reg(CFG_ACC_RADIUS, 32'd0);
    send_fix(31'(123456789), 32'(-98765432));
    send_fix(31'(123456790), 32'(-98765432));
    send_fix(31'(123456789), 32'(-98700000));
    send_fix(31'(123400000), 32'(-98000000));
    drain();

    // --- random phases, one waypoint setting each ---
    for (int p = 0; p < RandPhases; p++) begin
      send_idle_pct = 16;
      sink_idle_pct = 16;
      case (p)
        2: begin
          write_reg(CFG_TARGET_LAT, $urandom());
          write_reg(CFG_TARGET_LON, $urandom());
        end
        6: begin
          write_reg(CFG_TARGET_LAT, 32'(900000000));
          write_reg(CFG_TARGET_LON, 32'(-1800000000));
        end
        default: begin
          write_reg(CFG_TARGET_LAT,
                    32'(longint'($urandom_range(1800000000)) - 900000000));
          write_reg(CFG_TARGET_LON,
                    32'(longint'($urandom_range(32'd3600000000)) - 1800000000));
        end
      endcase
      case (p)
        0:       write_reg(CFG_COS_REF, 32'd65536);
        2:       write_reg(CFG_COS_REF, 32'd0);
        3:       write_reg(CFG_COS_REF, 32'h1_FFFF);
        6:       write_reg(CFG_COS_REF, $urandom_range(131071, 65537));
        default: write_reg(CFG_COS_REF, $urandom_range(65536));
      endcase
      case (p)
        0:       write_reg(CFG_ACC_RADIUS, 32'd1000);
        2, 7:    write_reg(CFG_ACC_RADIUS, 32'd0);
        3:       write_reg(CFG_ACC_RADIUS, 32'h1_FFFF);
        4:       write_reg(CFG_ACC_RADIUS, 32'd100000);
        default: write_reg(CFG_ACC_RADIUS, $urandom_range(100000));
      endcase
      // a stretch with no idling at all on either side
      if (p == 3) begin
        send_idle_pct = 0;
        sink_idle_pct = 0;
      end
      // hold the receiver off while fixes keep coming: fill up, stall input
      if (p == 5) begin
        send_idle_pct = 0;
        hold_requests++;
      end
      for (int n = 0; n < FixesPerPhase; n++) begin
        pick = $urandom_range(99);
        if (pick < 5) begin
          lat_v = wp_lat;
          lon_v = wp_lon;
        end else if (pick < 45) begin
          // near the waypoint, sometimes on a cardinal line
          lat_v = wp_lat + longint'($urandom_range(3000)) - 1500;
          lon_v = wp_lon + longint'($urandom_range(3000)) - 1500;
          if ($urandom_range(9) == 0) lat_v = wp_lat;
          else if ($urandom_range(9) == 0) lon_v = wp_lon;
        end else if (pick < 70) begin
          lat_v = wp_lat + longint'($urandom_range(32'h0020_0000)) - 64'h0010_0000;
          lon_v = wp_lon + longint'($urandom_range(32'h0020_0000)) - 64'h0010_0000;
        end else if (pick < 90) begin
          lat_v = longint'($urandom_range(1800000000)) - 900000000;
          lon_v = longint'($urandom_range(32'd3600000000)) - 1800000000;
        end else begin
          lat_v = longint'($urandom());
          lon_v = longint'($urandom());
        end
        send_fix(lat_v[LatW-1:0], lon_v[LonW-1:0]);
      end
      drain();
    end

    // let any stray beat show up before the verdict
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && backlog == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
hw/rtl/wdb_pkg.sv
hw/rtl/wdb_front.sv
hw/rtl/wdb_queue.sv
hw/rtl/wdb_back.sv
hw/rtl/waypoint_distance_bearing_core.sv
dv/wdb_fix_checker.sv
dv/tb_waypoint_distance_bearing_core.sv
